### rtl/core/rve_pkg.sv
// ============================================================================
// rve_pkg: shared types and constants of the register machine execute block
// Opcodes, sequencer states, widths and program counter helpers.
// ============================================================================
package rve_pkg;

    localparam int NUM_REGS  = 256;
    localparam int PC_BITS   = 16;
    localparam int IDX_W     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DATA_W    = 32;
    localparam int OPND_W    = 16;
    localparam int FUNC_W    = 4;
    localparam int NPC_W     = 16;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    typedef enum logic [FUNC_W-1:0] {
        F_SET    = 4'd0,
        F_COPY   = 4'd1,
        F_ADD    = 4'd2,
        F_SUB    = 4'd3,
        F_MUL    = 4'd4,
        F_DIV    = 4'd5,
        F_MAX    = 4'd6,
        F_MIN    = 4'd7,
        F_AND    = 4'd8,
        F_OR     = 4'd9,
        F_NOT    = 4'd10,
        F_GT     = 4'd11,
        F_LT     = 4'd12,
        F_EQ     = 4'd13,
        F_BRANCH = 4'd14,
        F_JUMP   = 4'd15
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_EXEC,
        ST_DIVIDE,
        ST_FIN
    } t_state;

    // Mask an operand to the counter width, zero extending if the counter is wider.
    function automatic logic [PC_BITS-1:0] pc_from_opnd(input logic [OPND_W-1:0] v);
        logic [PC_BITS-1:0] r;
        for (int i = 0; i < PC_BITS; i++) begin
            r[i] = (i < OPND_W) ? v[i % OPND_W] : 1'b0;
        end
        return r;
    endfunction

    // Low bits of the counter as seen on the result port.
    function automatic logic [NPC_W-1:0] pc_to_out(input logic [PC_BITS-1:0] v);
        logic [NPC_W-1:0] r;
        for (int i = 0; i < NPC_W; i++) begin
            r[i] = (i < PC_BITS) ? v[i % PC_BITS] : 1'b0;
        end
        return r;
    endfunction

endpackage

### rtl/core/rve_ram.sv
// ============================================================================
// rve_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ============================================================================
module rve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rve_div.sv
// ============================================================================
// rve_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, sign fixed up.
// ============================================================================
module rve_div
    import rve_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_dvd;
    logic [DATA_W-1:0]    r_mb;
    logic                 r_neg;

    logic [DATA_W:0]      w_trial;
    logic [DATA_W:0]      w_diff;
    logic                 w_qbit;

    assign w_trial = {r_rem, r_dvd[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_mb};
    assign w_qbit  = !w_diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(DATA_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend[DATA_W-1] ? (~i_dividend + DATA_W'(1)) : i_dividend;
            r_mb  <= i_divisor[DATA_W-1] ? (~i_divisor + DATA_W'(1)) : i_divisor;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            // shift dividend out, quotient bit in
            r_rem <= w_qbit ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            r_dvd <= {r_dvd[DATA_W-2:0], w_qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_dvd + DATA_W'(1)) : r_dvd;

endmodule

### rtl/core/register_vm_execute.sv
// ============================================================================
// register_vm_execute: three-address register machine execute unit
// Runs one instruction per input beat on a 32-bit register file and keeps
// the program counter; returns one result beat per instruction.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  input   | in        | i_valid / o_stall    | i_func, i_first_operand,
//          |           |                      | i_second_operand, i_third_operand
//  result  | out       | o_valid / i_stall    | o_next_pc, o_written_value,
//          |           |                      | o_wrote_register, o_divide_by_zero
//
//  Sequencing: an instruction runs through read A, read B, execute and finish
//  states of the sequencer, and a new beat is taken only in the idle state,
//  after the last one has finished. A divide with a nonzero divisor adds a
//  divide state that waits on the bit-serial divider, one step per quotient
//  bit. The single read port of the register RAM sets the two sequential
//  operand reads. Reset clears the counter and the per-entry valid bits at
//  once; an entry never written reads as zero. No clearing pass is needed.
//  A held result only delays the finish state; the result register parts
//  the two sides otherwise.
//
module register_vm_execute
    import rve_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [OPND_W-1:0]        i_first_operand,
    input  logic [OPND_W-1:0]        i_second_operand,
    input  logic [OPND_W-1:0]        i_third_operand,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [NPC_W-1:0]         o_next_pc,
    output logic signed [DATA_W-1:0] o_written_value,
    output logic                     o_wrote_register,
    output logic                     o_divide_by_zero
);

    // sequencer
    t_state r_state, n_state;

    // latched instruction
    t_func             r_func;
    logic [OPND_W-1:0] r_d0;
    logic [OPND_W-1:0] r_d1;
    logic [OPND_W-1:0] r_d2;

    // operands, quotient and flags
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_q;
    logic              r_dz;

    logic [PC_BITS-1:0]  r_pc;
    logic [NUM_REGS-1:0] r_valid_bits;
    logic [IDX_W-1:0]    r_rd_idx;

    // result register
    logic              r_o_valid;
    logic [NPC_W-1:0]  r_o_pc;
    logic [DATA_W-1:0] r_o_val;
    logic              r_o_wrote;
    logic              r_o_dz;

    logic [IDX_W-1:0]  w_raddr;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_rd_val;
    logic              w_we;
    logic              w_slot_free;
    logic              w_finish;
    logic              w_div_start;
    logic              w_div_done;
    logic [DATA_W-1:0] w_div_q;
    logic [DATA_W-1:0] w_prod;
    logic              w_gt;
    logic              w_lt;
    logic [DATA_W-1:0] w_val;
    logic              w_wrote;
    logic [PC_BITS-1:0] w_pc;

    // register file storage
    rve_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_d0[IDX_W-1:0]),
        .i_wdata (w_val),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rve_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_a),
        .i_divisor  (w_rd_val),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // an entry not yet written reads as zero
    assign w_rd_val = r_valid_bits[r_rd_idx] ? w_rdata : '0;

    // the result slot frees at this edge if empty or being taken
    assign w_slot_free = !r_o_valid || !i_stall;
    assign w_finish    = (r_state == ST_FIN) && w_slot_free;
    assign w_we        = w_finish && w_wrote;

    // next state and sequencer outputs
    always_comb begin
        n_state     = r_state;
        w_raddr     = r_d1[IDX_W-1:0];
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RD_A;
                end
            end
            ST_RD_A: begin
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                // branch tests the first operand's register instead
                w_raddr = (r_func == F_BRANCH) ? r_d0[IDX_W-1:0] : r_d2[IDX_W-1:0];
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if ((r_func == F_DIV) && (w_rd_val != '0)) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIVIDE;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIVIDE: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result value of the instruction
    assign w_prod = r_a * r_b;
    assign w_gt   = $signed(r_a) > $signed(r_b);
    assign w_lt   = $signed(r_a) < $signed(r_b);

    always_comb begin
        w_val   = '0;
        w_wrote = 1'b1;
        unique case (r_func)
            F_SET:    w_val = {r_d1, r_d2};
            F_COPY:   w_val = r_a;
            F_ADD:    w_val = r_a + r_b;
            F_SUB:    w_val = r_a - r_b;
            F_MUL:    w_val = w_prod;
            F_DIV:    w_val = r_dz ? '0 : r_q;
            F_MAX:    w_val = w_gt ? r_a : r_b;
            F_MIN:    w_val = w_lt ? r_a : r_b;
            F_AND:    w_val = DATA_W'((r_a != '0) && (r_b != '0));
            F_OR:     w_val = DATA_W'((r_a != '0) || (r_b != '0));
            F_NOT:    w_val = DATA_W'(r_a == '0);
            F_GT:     w_val = DATA_W'(w_gt);
            F_LT:     w_val = DATA_W'(w_lt);
            F_EQ:     w_val = DATA_W'(r_a == r_b);
            F_BRANCH: w_wrote = 1'b0;
            F_JUMP:   w_wrote = 1'b0;
            default:  w_wrote = 1'b0;
        endcase
    end

    // next counter: branch picks by the condition register held in r_b
    always_comb begin
        priority if (r_func == F_BRANCH) begin
            w_pc = (r_b != '0) ? pc_from_opnd(r_d1) : pc_from_opnd(r_d2);
        end else if (r_func == F_JUMP) begin
            w_pc = pc_from_opnd(r_d0);
        end else begin
            w_pc = r_pc + PC_BITS'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pc         <= '0;
            r_valid_bits <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_pc      <= w_pc;
                r_o_valid <= 1'b1;
                if (w_wrote) begin
                    r_valid_bits[r_d0[IDX_W-1:0]] <= 1'b1;
                end
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload: instruction, operands, result beat
    always_ff @(posedge i_clk) begin
        r_rd_idx <= w_raddr;
        if ((r_state == ST_IDLE) && i_valid) begin
            r_func <= t_func'(i_func);
            r_d0   <= i_first_operand;
            r_d1   <= i_second_operand;
            r_d2   <= i_third_operand;
        end
        if (r_state == ST_RD_B) begin
            r_a <= w_rd_val;
        end
        if (r_state == ST_EXEC) begin
            r_b  <= w_rd_val;
            r_dz <= (r_func == F_DIV) && (w_rd_val == '0);
        end
        if ((r_state == ST_DIVIDE) && w_div_done) begin
            r_q <= w_div_q;
        end
        if (w_finish) begin
            r_o_pc    <= pc_to_out(w_pc);
            r_o_val   <= w_val;
            r_o_wrote <= w_wrote;
            r_o_dz    <= r_dz;
        end
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_o_valid;
    assign o_next_pc        = r_o_pc;
    assign o_written_value  = $signed(r_o_val);
    assign o_wrote_register = r_o_wrote;
    assign o_divide_by_zero = r_o_dz;

endmodule
